// File: src/lcdtnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdtnw_pkg: shared definitions for the LCD text nibble writer
// Holds the default line length, byte codes, the nibble pair type and the
// Cyrillic glyph ROM used to map two-byte UTF-8 codes to LCD glyphs.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdtnw_pkg;

  // Default number of characters on one display line.
  localparam int unsigned LineCharsDefault = 20;

  // UTF-8 lead bytes of the Cyrillic block.
  localparam logic [7:0] LeadD0 = 8'hD0;
  localparam logic [7:0] LeadD1 = 8'hD1;

  // DDRAM address of the second display row.
  localparam logic [6:0] RowBaseSecond = 7'd64;

  // One byte that goes out on the bus as two nibbles, high nibble first.
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
  } pair_t;

  // Glyphs for capital letters in alphabet order, YO at position 6.
  localparam logic [7:0] GlyphUpper [33] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6,
    8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8, 8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA,
    8'h58, 8'hE1, 8'hAB, 8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1
  };

  // Glyphs for small letters in alphabet order, yo at position 6.
  localparam logic [7:0] GlyphLower [33] = '{
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9,
    8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE, 8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4,
    8'h78, 8'hE5, 8'hC0, 8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // Maps a lead and second byte to a glyph. Bit 8 of the result is the hit flag.
  function automatic logic [8:0] cyr_lookup(input logic [7:0] lead,
                                            input logic [7:0] second);
    logic [5:0] idx;
    logic       upper;
    logic       hit;
    logic [7:0] glyph;
    idx   = '0;
    upper = 1'b0;
    hit   = 1'b0;
    if (lead == LeadD0) begin
      if (second inside {[8'h90:8'h95]}) begin
        hit = 1'b1; upper = 1'b1; idx = 6'(second - 8'h90);
      end else if (second inside {[8'h96:8'hAF]}) begin
        hit = 1'b1; upper = 1'b1; idx = 6'(second - 8'h96) + 6'd7;
      end else if (second == 8'h81) begin
        hit = 1'b1; upper = 1'b1; idx = 6'd6;
      end else if (second inside {[8'hB0:8'hB5]}) begin
        hit = 1'b1; idx = 6'(second - 8'hB0);
      end else if (second inside {[8'hB6:8'hBF]}) begin
        hit = 1'b1; idx = 6'(second - 8'hB6) + 6'd7;
      end
    end else if (lead == LeadD1) begin
      if (second == 8'h91) begin
        hit = 1'b1; idx = 6'd6;
      end else if (second inside {[8'h80:8'h8F]}) begin
        hit = 1'b1; idx = 6'(second - 8'h80) + 6'd17;
      end
    end
    glyph = upper ? GlyphUpper[idx] : GlyphLower[idx];
    return {hit, glyph};
  endfunction

endpackage

`default_nettype wire

// File: src/lcd_text_nibble_writer_core.sv
// ----------------------------------------------------------------------------
// lcd_text_nibble_writer_core: text string to 4-bit character LCD bus writer
// Turns string bytes into set-address instruction nibbles and data nibbles.
// ----------------------------------------------------------------------------
`default_nettype none

// A string arrives one byte per input word. The word that has string_start set
// also carries the column and row, and causes a set-DDRAM-address instruction
// (two nibbles with register_select low) ahead of its character. Every
// character leaves as two data nibbles, high nibble first, and last_of_run
// marks the final nibble caused by one input word. UTF-8 Cyrillic pairs
// (lead byte 0xD0 or 0xD1) are folded into a single LCD glyph, so the lead
// byte itself gives no output. Rate: the output side moves one nibble per
// cycle while out_stall_i is low. The nibbles that one input word makes are
// two for each character or command: none for a held lead or a dropped
// byte, two for a plain character, and at most four for one word (a command
// and a character, or a character and a lead flushed at the end of the
// string). All decoding is done in the cycle the word is accepted. A one-word
// holding slot behind the output serializer lets the next word be accepted
// while the current one is still going out. in_stall_o rises only when that
// slot is occupied, and it stays high through the cycle in which the slot
// moves over to the serializer, so a new word can be taken in the cycle after.
module lcd_text_nibble_writer_core #(
  parameter int unsigned LINE_CHARS = lcdtnw_pkg::LineCharsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic [4:0] start_column_i,
  input  wire logic [1:0] start_row_i,
  input  wire logic       string_start_i,
  input  wire logic       string_end_i,
  // Output channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [3:0]      bus_nibble_o,
  output logic            register_select_o,
  output logic            last_of_run_o
);
  import lcdtnw_pkg::*;

  localparam int unsigned LeftW = $clog2(LINE_CHARS + 1);

  // String state carried from word to word.
  logic [7:0]       held_lead_q, held_lead_d;
  logic             lead_pending_q, lead_pending_d;
  logic [LeftW-1:0] bytes_left_q, bytes_left_d;

  // Serializer: the run going out now and one waiting run.
  pair_t      act_pair_q [3];
  logic [1:0] act_cnt_q;
  logic [1:0] act_idx_q;
  logic       act_lo_q;
  pair_t      pend_pair_q [3];
  logic [1:0] pend_cnt_q;

  // Decoded run of the word on the input ports.
  pair_t      run_pair [3];
  logic [1:0] run_cnt;
  pair_t      slot [3];
  logic [2:0] slot_vld;

  logic       in_fire;
  logic       out_fire;
  logic       act_done;
  logic       run_any;

  logic [6:0] row_base;
  logic [6:0] addr;
  logic       col_off;
  logic [8:0] lookup;
  logic       pend_eff;
  logic [LeftW-1:0] left_eff;

  assign in_stall_o = (pend_cnt_q != 2'd0);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_o && !out_stall_i;
  assign act_done   = out_fire && act_lo_q && (act_idx_q == act_cnt_q - 2'd1);
  assign run_any    = (run_cnt != 2'd0);

  // Word decoding: command, one character, and an end-of-string flush.
  always_comb begin
    case (start_row_i)
      2'd0:    row_base = 7'd0;
      2'd1:    row_base = RowBaseSecond;
      2'd2:    row_base = 7'(LINE_CHARS);
      default: row_base = RowBaseSecond + 7'(LINE_CHARS);
    endcase
    addr    = row_base + {2'b00, start_column_i};
    col_off = ({2'b00, start_column_i} >= 7'(LINE_CHARS));
    lookup  = cyr_lookup(held_lead_q, text_byte_i);

    slot_vld       = '0;
    slot[0]        = '{rs: 1'b0, data: {1'b1, addr}};
    slot[1]        = '{rs: 1'b1, data: text_byte_i};
    slot[2]        = '{rs: 1'b1, data: held_lead_q};
    held_lead_d    = held_lead_q;
    pend_eff       = lead_pending_q;
    left_eff       = bytes_left_q;

    if (string_start_i) begin
      pend_eff = 1'b0;
      if (col_off) begin
        left_eff = '0;
      end else begin
        left_eff    = LeftW'(LINE_CHARS) - LeftW'(start_column_i);
        slot_vld[0] = 1'b1;
      end
    end

    lead_pending_d = 1'b0;
    bytes_left_d   = left_eff;
    if (pend_eff) begin
      slot_vld[1] = 1'b1;
      if (lookup[8]) begin
        slot[1].data = lookup[7:0];
        if (left_eff != '0) bytes_left_d = left_eff - LeftW'(1);
      end else if (text_byte_i != held_lead_q) begin
        if (left_eff != '0) bytes_left_d = left_eff - LeftW'(1);
      end else begin
        // Repeated lead: the old lead goes out and the new one is held.
        slot[1].data = held_lead_q;
        if (left_eff != '0) begin
          bytes_left_d   = left_eff - LeftW'(1);
          held_lead_d    = text_byte_i;
          lead_pending_d = 1'b1;
        end
      end
    end else if (left_eff != '0) begin
      bytes_left_d = left_eff - LeftW'(1);
      if (text_byte_i == LeadD0 || text_byte_i == LeadD1) begin
        held_lead_d    = text_byte_i;
        lead_pending_d = 1'b1;
      end else begin
        slot_vld[1] = 1'b1;
      end
    end

    slot[2].data = held_lead_d;
    if (string_end_i) begin
      if (lead_pending_d) begin
        slot_vld[2]    = 1'b1;
        lead_pending_d = 1'b0;
      end
      bytes_left_d = '0;
    end

    // Pack the valid pairs to the front of the run.
    run_cnt = 2'd0;
    for (int k = 0; k < 3; k++) begin
      run_pair[k] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      if (slot_vld[k]) begin
        run_pair[run_cnt] = slot[k];
        run_cnt           = run_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lead_q    <= '0;
      lead_pending_q <= 1'b0;
      bytes_left_q   <= '0;
    end else if (in_fire) begin
      held_lead_q    <= held_lead_d;
      lead_pending_q <= lead_pending_d;
      bytes_left_q   <= bytes_left_d;
    end
  end

  // Serializer control. A finished run is replaced by the waiting one first,
  // otherwise by a run accepted in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cnt_q  <= 2'd0;
      act_idx_q  <= 2'd0;
      act_lo_q   <= 1'b0;
      pend_cnt_q <= 2'd0;
    end else if (act_done || act_cnt_q == 2'd0) begin
      act_idx_q <= 2'd0;
      act_lo_q  <= 1'b0;
      if (pend_cnt_q != 2'd0) begin
        act_cnt_q  <= pend_cnt_q;
        pend_cnt_q <= 2'd0;
      end else if (in_fire) begin
        act_cnt_q <= run_cnt;
      end else begin
        act_cnt_q <= 2'd0;
      end
    end else begin
      if (out_fire) begin
        act_lo_q <= !act_lo_q;
        if (act_lo_q) act_idx_q <= act_idx_q + 2'd1;
      end
      if (in_fire && run_any) begin
        pend_cnt_q <= run_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_done || act_cnt_q == 2'd0) begin
      if (pend_cnt_q != 2'd0) begin
        act_pair_q <= pend_pair_q;
      end else if (in_fire) begin
        act_pair_q <= run_pair;
      end
    end else if (in_fire && run_any) begin
      pend_pair_q <= run_pair;
    end
  end

  // Output side: one nibble of the current pair.
  assign out_valid_o       = (act_cnt_q != 2'd0);
  assign register_select_o = act_pair_q[act_idx_q].rs;
  assign bus_nibble_o      = act_lo_q ? act_pair_q[act_idx_q].data[3:0]
                                      : act_pair_q[act_idx_q].data[7:4];
  assign last_of_run_o     = act_lo_q && (act_idx_q == act_cnt_q - 2'd1);

endmodule

`default_nettype wire

// File: src/lcd_text_nibble_writer_checker.sv
// ----------------------------------------------------------------------------
// lcd_text_nibble_writer_checker: port-level checks for the nibble writer
// Watches the handshake and the holding-slot behavior seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_text_nibble_writer_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] bus_nibble_o,
  input wire logic       register_select_o,
  input wire logic       last_of_run_o
);

  // A stalled output word stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
  else $error("output word dropped while stalled");

  // A stalled output word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(bus_nibble_o) && $stable(register_select_o) && $stable(last_of_run_o))
  else $error("output payload changed while stalled");

  // The input only stalls while a run is going out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
  else $error("input stalled with no output pending");

  // The holding slot fills only on an accepted input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !in_valid_i |=> !in_stall_o)
  else $error("input stall rose without an accepted word");

endmodule

bind lcd_text_nibble_writer_core lcd_text_nibble_writer_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .bus_nibble_o     (bus_nibble_o),
  .register_select_o(register_select_o),
  .last_of_run_o    (last_of_run_o)
);

`default_nettype wire

// File: tb/lcd_text_nibble_writer_core_tb.sv
// ----------------------------------------------------------------------------
// lcd_text_nibble_writer_core_tb: self-checking bench for the LCD text writer
// Sends strings (plain bytes, Cyrillic UTF-8 pairs, broken pairs, overlong
// and off-line strings) one word at a time. Every accepted word is run
// through a local model of the writer, and every bus nibble that comes out
// is checked against the oldest predicted nibble, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_text_nibble_writer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineChars   = lcdtnw_pkg::LineCharsDefault;
  localparam int unsigned RandomWords = 370;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned MaxReports  = 40;

  // Lead bytes of the Cyrillic block and the set-DDRAM-address opcode.
  localparam logic [7:0] LeadUpper  = 8'hD0;
  localparam logic [7:0] LeadLower  = 8'hD1;
  localparam logic [7:0] SetAddrCmd = 8'h80;
  // Register select values on the bus.
  localparam logic RsInstr = 1'b0;
  localparam logic RsData  = 1'b1;

  // LCD character generator codes for capitals and small letters, in
  // alphabet order with YO at position 6.
  localparam logic [7:0] CapGlyph [33] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6,
    8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8, 8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA,
    8'h58, 8'hE1, 8'hAB, 8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1
  };
  localparam logic [7:0] SmallGlyph [33] = '{
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9,
    8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE, 8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4,
    8'h78, 8'hE5, 8'hC0, 8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  // One input word of a string.
  typedef struct packed {
    logic [7:0] text;
    logic [4:0] col;
    logic [1:0] row;
    logic       first;
    logic       last;
  } text_word_t;

  // One enable strobe on the LCD bus.
  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       last;
  } bus_write_t;

  // Clock and reset. The reset is asserted from time zero and released once.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Every input of the block starts at a known value.
  logic       in_valid     = 1'b0;
  logic [7:0] text_byte    = '0;
  logic [4:0] start_column = '0;
  logic [1:0] start_row    = '0;
  logic       string_start = 1'b0;
  logic       string_end   = 1'b0;
  logic       out_stall    = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic [3:0] bus_nibble;
  logic       register_select;
  logic       last_of_run;

  // Words waiting to be sent, and bus writes predicted but not yet seen.
  text_word_t send_q[$];
  bus_write_t bus_writes_q[$];
  // Nibbles caused by the word being predicted, before last is marked.
  bus_write_t word_nibbles_q[$];

  // State of the local writer model.
  logic [7:0]  held_lead    = '0;
  logic        lead_waiting = 1'b0;
  int unsigned chars_left   = 0;

  int unsigned words_total = 0;
  int unsigned strings_sent = 0;
  int unsigned words_in     = 0;
  int unsigned nibbles_out  = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned hold_left    = 0;
  logic [1:0]  holds_done   = '0;

  text_word_t next_word;
  bus_write_t oldest_write;

  lcd_text_nibble_writer_core #(
    .LINE_CHARS(LineChars)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .text_byte_i      (text_byte),
    .start_column_i   (start_column),
    .start_row_i      (start_row),
    .string_start_i   (string_start),
    .string_end_i     (string_end),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .bus_nibble_o     (bus_nibble),
    .register_select_o(register_select),
    .last_of_run_o    (last_of_run)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Writer model
  // ---------------------------------------------------------------------------

  // Maps a lead byte and a second byte to a glyph; returns 1 on a hit.
  function automatic bit map_cyrillic(input logic [7:0] lead, input logic [7:0] second,
                                      output logic [7:0] glyph);
    int s;
    s     = int'(second);
    glyph = 8'h00;
    if (lead == LeadUpper) begin
      if (s >= 'h90 && s <= 'h95) begin
        glyph = CapGlyph[s - 'h90];
        return 1'b1;
      end
      if (s >= 'h96 && s <= 'hAF) begin
        glyph = CapGlyph[7 + s - 'h96];
        return 1'b1;
      end
      if (s == 'h81) begin
        glyph = CapGlyph[6];
        return 1'b1;
      end
      if (s >= 'hB0 && s <= 'hB5) begin
        glyph = SmallGlyph[s - 'hB0];
        return 1'b1;
      end
      if (s >= 'hB6 && s <= 'hBF) begin
        glyph = SmallGlyph[7 + s - 'hB6];
        return 1'b1;
      end
    end else if (lead == LeadLower) begin
      if (s == 'h91) begin
        glyph = SmallGlyph[6];
        return 1'b1;
      end
      if (s >= 'h80 && s <= 'h8F) begin
        glyph = SmallGlyph[17 + s - 'h80];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // A character leaves as two data nibbles, high nibble first.
  function automatic void add_char(input logic [7:0] c);
    word_nibbles_q.push_back('{c[7:4], RsData, 1'b0});
    word_nibbles_q.push_back('{c[3:0], RsData, 1'b0});
  endfunction

  // Works out the bus writes that one accepted word causes and queues them.
  function automatic void predict_bus_writes(input text_word_t w);
    int unsigned base;
    logic [6:0]  addr;
    logic [7:0]  cmd;
    logic [7:0]  glyph;
    bus_write_t  bw;
    word_nibbles_q.delete();

    if (w.first) begin
      // A new string throws away any lead byte left over from the last one.
      lead_waiting = 1'b0;
      if (w.col >= LineChars) begin
        // The column is off the line, so the whole string is dropped.
        chars_left = 0;
      end else begin
        case (w.row)
          2'd0:    base = 0;
          2'd1:    base = 64;
          2'd2:    base = LineChars;
          default: base = 64 + LineChars;
        endcase
        addr       = 7'(base + w.col);
        cmd        = {1'b0, addr} | SetAddrCmd;
        chars_left = LineChars - w.col;
        word_nibbles_q.push_back('{cmd[7:4], RsInstr, 1'b0});
        word_nibbles_q.push_back('{addr[3:0], RsInstr, 1'b0});
      end
    end

    if (lead_waiting) begin
      // A held lead pairs with this byte even when the string has no room left.
      lead_waiting = 1'b0;
      if (map_cyrillic(held_lead, w.text, glyph)) begin
        add_char(glyph);
        if (chars_left > 0) chars_left--;
      end else if (w.text != held_lead) begin
        add_char(w.text);
        if (chars_left > 0) chars_left--;
      end else begin
        // A repeated lead: the first one goes out, the second is held again
        // only if the string still has room for it.
        add_char(held_lead);
        if (chars_left > 0) begin
          chars_left--;
          held_lead    = w.text;
          lead_waiting = 1'b1;
        end
      end
    end else if (chars_left > 0) begin
      chars_left--;
      if (w.text == LeadUpper || w.text == LeadLower) begin
        held_lead    = w.text;
        lead_waiting = 1'b1;
      end else begin
        add_char(w.text);
      end
    end

    if (w.last) begin
      if (lead_waiting) begin
        add_char(held_lead);
        lead_waiting = 1'b0;
      end
      chars_left = 0;
    end

    foreach (word_nibbles_q[i]) begin
      bw      = word_nibbles_q[i];
      bw.last = (i == word_nibbles_q.size() - 1);
      bus_writes_q.push_back(bw);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queues one word; column and row are random unless the word starts a string.
  task automatic add_word(input logic [7:0] text, input logic [4:0] col,
                          input logic [1:0] row, input logic first, input logic last);
    text_word_t w;
    w.text  = text;
    w.col   = first ? col : 5'($urandom_range(31));
    w.row   = first ? row : 2'($urandom_range(3));
    w.first = first;
    w.last  = last;
    send_q.push_back(w);
    if (first) strings_sent++;
  endtask

  // Queues one random string and returns how many of its bytes fit the line.
  task automatic add_random_string(output int unsigned taken);
    logic [7:0]  text_seq[$];
    logic [7:0]  lead;
    logic [4:0]  col;
    logic [1:0]  row;
    int unsigned room;
    int unsigned target_len;
    int unsigned pick;
    int unsigned extra;
    col  = ($urandom_range(9) == 0) ? 5'($urandom_range(31, LineChars))
                                    : 5'($urandom_range(LineChars - 1));
    row  = 2'($urandom_range(3));
    room = (col < LineChars) ? LineChars - col : 0;
    // Most strings are short; now and then one runs past the end of the line.
    if (room == 0)
      target_len = $urandom_range(1, 3);
    else if ($urandom_range(4) == 0)
      target_len = room + $urandom_range(4);
    else
      target_len = $urandom_range(1, (room < 8) ? room : 8);

    while (text_seq.size() < target_len) begin
      pick = $urandom_range(99);
      lead = $urandom_range(1) ? LeadLower : LeadUpper;
      if (pick < 40) begin
        text_seq.push_back(8'($urandom_range(255)));
      end else if (pick < 75) begin
        // Well-formed Cyrillic pair, mapped or not.
        text_seq.push_back(lead);
        text_seq.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end else if (pick < 83) begin
        text_seq.push_back(lead);
        text_seq.push_back(lead);
      end else if (pick < 90) begin
        // Broken pair: lead followed by any byte.
        text_seq.push_back(lead);
        text_seq.push_back(8'($urandom_range(255)));
      end else if (pick < 95) begin
        text_seq.push_back($urandom_range(1) ? 8'h00 : 8'hFF);
      end else begin
        // A lone lead at the end is emitted unchanged when the string ends.
        text_seq.push_back(lead);
      end
    end

    foreach (text_seq[i])
      add_word(text_seq[i], col, row, i == 0,
               (i == text_seq.size() - 1) && ($urandom_range(9) != 0));

    // Noise after the string: bytes without a string start.
    if ($urandom_range(6) == 0) begin
      extra = $urandom_range(1, 2);
      repeat (extra) add_word(8'($urandom_range(255)), '0, '0, 1'b0, 1'($urandom_range(1)));
    end
    taken = (text_seq.size() < room) ? text_seq.size() : room;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("[%0t] mismatch on word %0d, nibble %0d: %s", $time, words_in, nibbles_out,
               what);
  endtask

  // The sender idles 35 percent and the receiver stalls 87 percent in the first
  // third, the other way round in the second third, and neither in the rest.
  function automatic int unsigned send_idle_pct();
    if (words_in < words_total / 3)     return 35;
    if (words_in < 2 * words_total / 3) return 87;
    return 0;
  endfunction

  function automatic int unsigned recv_stall_pct();
    if (words_in < words_total / 3)     return 87;
    if (words_in < 2 * words_total / 3) return 35;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the next queued word and holds it while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        next_word     = send_q.pop_front();
        in_valid     <= 1'b1;
        text_byte    <= next_word.text;
        start_column <= next_word.col;
        start_row    <= next_word.row;
        string_start <= next_word.first;
        string_end   <= next_word.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long hold-offs of the receiver: twice in the run the output side is
  // stalled for a long stretch while the sender keeps offering words, so the
  // holding slot fills and the input side must stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!holds_done[0] && words_in >= 40) begin
      hold_left     <= HoldCycles;
      holds_done[0] <= 1'b1;
    end else if (!holds_done[1] && words_in >= words_total - 60) begin
      hold_left     <= HoldCycles;
      holds_done[1] <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni)
      out_stall <= 1'b0;
    else
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct());
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted word, then checks each accepted nibble.
  // Both happen in this one block so a same-cycle result cannot race the
  // prediction it is checked against.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        predict_bus_writes('{text_byte, start_column, start_row, string_start, string_end});
        words_in <= words_in + 1;
      end
      if (out_valid && !out_stall) begin
        nibbles_out <= nibbles_out + 1;
        if (bus_writes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected nibble %h rs %b last %b",
                                    bus_nibble, register_select, last_of_run));
        end else begin
          oldest_write = bus_writes_q.pop_front();
          if (bus_nibble !== oldest_write.nibble)
            report_mismatch($sformatf("bus_nibble %h, expected %h",
                                      bus_nibble, oldest_write.nibble));
          if (register_select !== oldest_write.rs)
            report_mismatch($sformatf("register_select %b, expected %b",
                                      register_select, oldest_write.rs));
          if (last_of_run !== oldest_write.last)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      last_of_run, oldest_write.last));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d nibbles outstanding", cycles,
               bus_writes_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_taken;
    int unsigned taken;
    random_taken = 0;

    // Byte 0x00 and 0xFF as plain characters at the top left corner.
    add_word(8'h00, 5'd0, 2'd0, 1'b1, 1'b0);
    add_word(8'hFF, '0, '0, 1'b0, 1'b0);
    // Mapped pairs: capital A, capital YO, small yo, small ya.
    add_word(LeadUpper, '0, '0, 1'b0, 1'b0);
    add_word(8'h90, '0, '0, 1'b0, 1'b0);
    add_word(LeadUpper, '0, '0, 1'b0, 1'b0);
    add_word(8'h81, '0, '0, 1'b0, 1'b0);
    add_word(LeadLower, '0, '0, 1'b0, 1'b0);
    add_word(8'h91, '0, '0, 1'b0, 1'b0);
    add_word(LeadLower, '0, '0, 1'b0, 1'b0);
    add_word(8'h8F, '0, '0, 1'b0, 1'b0);
    // Lead repeated: the first goes out and the second is held again, then a
    // byte that does not pair goes out as it is.
    add_word(LeadUpper, '0, '0, 1'b0, 1'b0);
    add_word(LeadUpper, '0, '0, 1'b0, 1'b0);
    add_word(8'h41, '0, '0, 1'b0, 1'b0);
    // A lead on the last byte of the string is flushed unchanged.
    add_word(LeadLower, '0, '0, 1'b0, 1'b1);
    // Last column of the last row: the lead is the only byte that fits, yet
    // it still pairs; what follows is dropped, and the end flag too.
    add_word(LeadUpper, 5'd19, 2'd3, 1'b1, 1'b0);
    add_word(8'hB5, '0, '0, 1'b0, 1'b0);
    add_word(8'h78, '0, '0, 1'b0, 1'b0);
    add_word(8'h79, '0, '0, 1'b0, 1'b1);
    // Column past the end of the line drops the whole string.
    add_word(8'h51, 5'd31, 2'd2, 1'b1, 1'b0);
    add_word(8'h52, '0, '0, 1'b0, 1'b1);
    // A new string while a lead is held discards the lead.
    add_word(LeadLower, 5'd5, 2'd1, 1'b1, 1'b0);
    add_word(8'h7A, 5'd0, 2'd2, 1'b1, 1'b1);
    // A byte after the end without a new start is dropped.
    add_word(8'h6B, '0, '0, 1'b0, 1'b0);
    // Start and end on one lead byte: command plus the flushed lead.
    add_word(LeadUpper, 5'd10, 2'd2, 1'b1, 1'b1);

    // Random strings fill the queue up to about the planned number of words.
    while (send_q.size() < RandomWords) begin
      add_random_string(taken);
      random_taken += taken;
    end
    words_total = send_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_in < words_total || bus_writes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (bus_writes_q.size() != 0)
      report_mismatch($sformatf("%0d predicted nibbles never came out", bus_writes_q.size()));

    $display("Sent %0d words in %0d strings (%0d random bytes on the line), %0d nibbles.",
             words_total, strings_sent, random_taken, nibbles_out);
    $display("Covered Cyrillic and broken pairs, overlong lines, long stalls; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/lcdtnw_pkg.sv
src/lcd_text_nibble_writer_core.sv
src/lcd_text_nibble_writer_checker.sv
tb/lcd_text_nibble_writer_core_tb.sv
